// ===== sv/sdbd_pkg.sv =====
package sdbd_pkg;

	localparam int unsigned CFG_DW = 32;
	localparam int unsigned CFG_IW = 3;

	localparam logic [2:0] CFG_CARD_PRESENT = 3'd0;
	localparam logic [2:0] CFG_STUCK_BUSY   = 3'd1;
	localparam logic [2:0] CFG_FAIL_AFTER   = 3'd2;
	localparam logic [2:0] CFG_READ_BUDGET  = 3'd3;
	localparam logic [2:0] CFG_WRITE_BUDGET = 3'd4;

	localparam logic MODE_RD = 1'b0;
	localparam logic MODE_WR = 1'b1;

	localparam logic [3:0] OFS_LBA_HI = 4'd0;
	localparam logic [3:0] OFS_LBA_LO = 4'd1;
	localparam logic [3:0] OFS_DATA   = 4'd2;
	localparam logic [3:0] OFS_CMD    = 4'd3;

	localparam logic [7:0] CMD_READ     = 8'h01;
	localparam logic [7:0] CMD_WRITE    = 8'h02;
	localparam logic [7:0] CMD_SET_HIGH = 8'h03;

	localparam logic [7:0] RDATA_UNUSED = 8'hFF;

	typedef struct packed {
		logic error;
		logic card;
		logic busy;
	} status_t;

endpackage

// ===== sv/sd_block_device_registers.sv =====
// Block storage register window. Four byte offsets: block number high and low byte (a write
// resets the data cursor), a data port that streams through a BLOCK_SIZE byte buffer, and a
// status/command register. Items are taken one at a time. A register access gives its word
// in the cycle after it is taken; a data-port read passes through the buffer memory read
// register and then the output register. Read block and write block commands return their
// word at once and then copy the block between the buffer memory and the disk memory one
// byte per cycle; the next item waits for the copy. A read of a block beyond the disk instead
// zero-fills the buffer; a write beyond it or a failed command copies nothing. After reset,
// a clearing pass zeroes both memories first; configuration writes are taken at any time.
module sd_block_device_registers #(
	parameter int unsigned BLOCK_SIZE  = 512,
	parameter int unsigned DISK_BLOCKS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sdbd_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [sdbd_pkg::CFG_DW-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [3:0]                        offset,
	input  logic [7:0]                        wdata,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        rdata
);

	import sdbd_pkg::*;

	localparam int unsigned DISK_DEPTH = DISK_BLOCKS * BLOCK_SIZE;
	localparam int unsigned BA  = $clog2(BLOCK_SIZE);
	localparam int unsigned DA  = $clog2(DISK_DEPTH);
	localparam int unsigned DBW = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDBUF,
		ST_COPY,
		ST_DRAIN,
		ST_ZERO
	} state_t;

	state_t         state_q;
	logic           card_q;
	logic           busy_q;
	logic [31:0]    fail_after_q;
	logic [15:0]    reads_to_fail_q;
	logic [15:0]    writes_to_fail_q;
	logic [15:0]    block_low_q;
	logic [15:0]    block_high_q;
	logic [BA-1:0]  cursor_q;
	logic           error_q;
	logic [31:0]    count_q;
	logic [DA-1:0]  cnt_q;
	logic [DA-1:0]  daddr_q;
	logic           dir_wr_q;
	logic           cp_v_s1;
	logic [BA-1:0]  cp_bidx_s1;
	logic [DA-1:0]  cp_didx_s1;
	logic           out_valid_q;
	logic [7:0]     rdata_q;

	logic           accept;
	logic [BA-1:0]  cursor_next;
	logic           cnt_inc;
	logic [31:0]    cnt_next;
	logic           perm_fail;
	logic           in_range;
	logic [DA-1:0]  base;
	status_t        status;

	logic           buf_we;
	logic [BA-1:0]  buf_waddr;
	logic [7:0]     buf_wdata;
	logic [BA-1:0]  buf_raddr;
	logic [7:0]     buf_rdata;
	logic           disk_we;
	logic [DA-1:0]  disk_waddr;
	logic [7:0]     disk_wdata;
	logic [7:0]     disk_rdata;

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign rdata     = rdata_q;

	assign cursor_next = (cursor_q == BA'(BLOCK_SIZE - 1)) ? cursor_q : cursor_q + 1'b1;

	assign cnt_inc   = ((wdata == CMD_READ) || (wdata == CMD_WRITE)) && (count_q != '1);
	assign cnt_next  = count_q + 32'(cnt_inc);
	assign perm_fail = (wdata == CMD_READ) && !fail_after_q[31] && (cnt_next > fail_after_q);
	assign in_range  = (block_high_q == '0) && ({1'b0, block_low_q} < 17'(DISK_BLOCKS));
	assign base      = DA'(DA'(block_low_q[DBW-1:0]) * DA'(BLOCK_SIZE));

	assign status.error = error_q;
	assign status.card  = card_q;
	assign status.busy  = busy_q;

	assign buf_raddr = (state_q == ST_IDLE) ? cursor_q : cnt_q[BA-1:0];

	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = cp_bidx_s1;
		buf_wdata = disk_rdata;
		if (state_q == ST_CLEAR) begin
			buf_we    = (cnt_q <= DA'(BLOCK_SIZE - 1));
			buf_waddr = cnt_q[BA-1:0];
			buf_wdata = '0;
		end else if (state_q == ST_ZERO) begin
			buf_we    = 1'b1;
			buf_waddr = cnt_q[BA-1:0];
			buf_wdata = '0;
		end else if (cp_v_s1 && !dir_wr_q) begin
			buf_we = 1'b1;
		end else if (accept && (mode == MODE_WR) && (offset == OFS_DATA)) begin
			buf_we    = 1'b1;
			buf_waddr = cursor_q;
			buf_wdata = wdata;
		end
	end

	always_comb begin
		disk_we    = 1'b0;
		disk_waddr = cp_didx_s1;
		disk_wdata = buf_rdata;
		if (state_q == ST_CLEAR) begin
			disk_we    = 1'b1;
			disk_waddr = cnt_q;
			disk_wdata = '0;
		end else if (cp_v_s1 && dir_wr_q) begin
			disk_we = 1'b1;
		end
	end

	sdbd_ram #(
		.DEPTH (BLOCK_SIZE),
		.AW    (BA),
		.DW    (8)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	sdbd_ram #(
		.DEPTH (DISK_DEPTH),
		.AW    (DA),
		.DW    (8)
	) u_disk (
		.clk   (clk),
		.we    (disk_we),
		.waddr (disk_waddr),
		.wdata (disk_wdata),
		.raddr (daddr_q),
		.rdata (disk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			card_q           <= 1'b0;
			busy_q           <= 1'b0;
			fail_after_q     <= '1;
			reads_to_fail_q  <= '0;
			writes_to_fail_q <= '0;
			block_low_q      <= '0;
			block_high_q     <= '0;
			cursor_q         <= '0;
			error_q          <= 1'b0;
			count_q          <= '0;
			cnt_q            <= '0;
			daddr_q          <= '0;
			dir_wr_q         <= 1'b0;
			cp_v_s1          <= 1'b0;
			cp_bidx_s1       <= '0;
			cp_didx_s1       <= '0;
			out_valid_q      <= 1'b0;
			rdata_q          <= '0;
		end else begin
			if (out_valid_q && !out_stall && !accept) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == DA'(DISK_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_RD) begin
							out_valid_q <= (offset != OFS_DATA);
							unique case (offset)
								OFS_LBA_HI: rdata_q <= block_low_q[15:8];
								OFS_LBA_LO: rdata_q <= block_low_q[7:0];
								OFS_DATA: begin
									cursor_q <= cursor_next;
									state_q  <= ST_RDBUF;
								end
								OFS_CMD: rdata_q <= {5'd0, status};
								default: rdata_q <= RDATA_UNUSED;
							endcase
						end else begin
							out_valid_q <= 1'b1;
							rdata_q     <= '0;
							unique case (offset)
								OFS_LBA_HI: begin
									block_low_q[15:8] <= wdata;
									cursor_q          <= '0;
								end
								OFS_LBA_LO: begin
									block_low_q[7:0] <= wdata;
									cursor_q         <= '0;
								end
								OFS_DATA: cursor_q <= cursor_next;
								OFS_CMD: begin
									cursor_q <= '0;
									if (wdata == CMD_SET_HIGH) begin
										error_q      <= 1'b0;
										block_high_q <= block_low_q;
									end else if (!card_q) begin
										error_q <= 1'b1;
									end else begin
										count_q <= cnt_next;
										if (perm_fail) begin
											error_q <= 1'b1;
										end else if ((wdata == CMD_READ) &&
											(reads_to_fail_q != '0)) begin
											reads_to_fail_q <= reads_to_fail_q - 1'b1;
											error_q         <= 1'b1;
										end else if ((wdata == CMD_WRITE) &&
											(writes_to_fail_q != '0)) begin
											writes_to_fail_q <= writes_to_fail_q - 1'b1;
											error_q          <= 1'b1;
										end else if (wdata == CMD_READ) begin
											cnt_q   <= '0;
											error_q <= !in_range;
											if (in_range) begin
												dir_wr_q <= 1'b0;
												daddr_q  <= base;
												state_q  <= ST_COPY;
											end else begin
												state_q <= ST_ZERO;
											end
										end else if (wdata == CMD_WRITE) begin
											cnt_q   <= '0;
											error_q <= !in_range;
											if (in_range) begin
												dir_wr_q <= 1'b1;
												daddr_q  <= base;
												state_q  <= ST_COPY;
											end
										end else begin
											error_q <= 1'b0;
										end
									end
								end
								default: ;
							endcase
						end
					end
				end
				ST_RDBUF: begin
					rdata_q     <= buf_rdata;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_COPY: begin
					cp_v_s1    <= 1'b1;
					cp_bidx_s1 <= cnt_q[BA-1:0];
					cp_didx_s1 <= daddr_q;
					daddr_q    <= daddr_q + 1'b1;
					if (cnt_q[BA-1:0] == BA'(BLOCK_SIZE - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					cp_v_s1 <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_ZERO: begin
					if (cnt_q[BA-1:0] == BA'(BLOCK_SIZE - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CARD_PRESENT: card_q <= cfg_data[0];
					CFG_STUCK_BUSY:   busy_q <= cfg_data[0];
					CFG_FAIL_AFTER:   fail_after_q <= cfg_data[31:0];
					CFG_READ_BUDGET:  reads_to_fail_q <= cfg_data[15:0];
					CFG_WRITE_BUDGET: writes_to_fail_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= BA'(BLOCK_SIZE - 1))
		else $error("data cursor beyond last buffer byte");

	a_no_word_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("word presented during clearing pass");

	a_copy_stage: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_s1 |-> ((state_q == ST_COPY) || (state_q == ST_DRAIN)))
		else $error("copy write stage active outside a block copy");

	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !((mode == MODE_RD) && (offset == OFS_DATA))) |=> out_valid_q)
		else $error("accepted access gave no word");

	a_rdbuf_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDBUF) |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("data port read gave no word");

endmodule

// ===== sv/sdbd_ram.sv =====
module sdbd_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9,
	parameter int unsigned DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
